### design/tewt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// tewt_pkg
// Shared types and constants of the flight-time and energy window trigger.
// -----------------------------------------------------------------------------
package tewt_pkg;

	localparam int ROOT_FRAC_BITS = 24;
	localparam int KEV_PER_MEV    = 1000;
	localparam int KEV_W          = 14;
	localparam int TIME_W         = 48;
	localparam int TOF_W          = TIME_W + 1;
	localparam int AMP_W          = 16;
	localparam int COEF_W         = 32;
	localparam int ADDR_W         = 5;

	// 1000 * 2^48 fits in 58 bits; its root in 29 bits; root * 1000 in 39 bits
	localparam int INV_W          = 58;
	localparam int ROOT_W         = INV_W / 2;
	localparam int SCL_W          = ROOT_W + 10;
	localparam int UHI_W          = SCL_W - ROOT_FRAC_BITS;

	localparam int DIV1_STEPS     = INV_W;
	localparam int SQRT_STEPS     = ROOT_W;
	localparam int DIV2_STEPS     = SCL_W;
	localparam int CHAIN_STAGES   = DIV1_STEPS + SQRT_STEPS + DIV2_STEPS + 3;

	localparam logic [INV_W-1:0] INV_NUM = INV_W'(KEV_PER_MEV) << (2 * ROOT_FRAC_BITS);

	typedef enum logic [2:0] {
		REG_C0   = 3'd0,
		REG_C1   = 3'd1,
		REG_C2   = 3'd2,
		REG_HWIN = 3'd3,
		REG_EMIN = 3'd4,
		REG_EMAX = 3'd5,
		REG_THR1 = 3'd6,
		REG_THR2 = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] c0;
		logic signed [COEF_W-1:0] c1;
		logic signed [COEF_W-1:0] c2;
		logic [30:0]              half_win;
		logic [KEV_W-1:0]         emin;
		logic [KEV_W-1:0]         emax;
		logic [AMP_W-1:0]         thr1;
		logic [AMP_W-1:0]         thr2;
	} cfg_t;

	typedef struct packed {
		logic                    ok;
		logic [KEV_W-1:0]        kev;
		logic signed [TOF_W-1:0] tof1;
		logic signed [TOF_W-1:0] tof2;
		logic                    pre1;
		logic                    pre2;
	} side_t;

endpackage
`default_nettype wire

### design/tewt_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// tewt event and result channels
// Valid/ready channels carrying one event and one trigger decision.
// -----------------------------------------------------------------------------
interface tewt_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  cluster_count;
	logic [13:0] cluster_energy_kev;
	logic [47:0] cluster_time;
	logic        first_hit_present;
	logic [47:0] first_hit_time;
	logic [15:0] first_hit_amp;
	logic        second_hit_present;
	logic [47:0] second_hit_time;
	logic [15:0] second_hit_amp;

	modport source (output valid, cluster_count, cluster_energy_kev, cluster_time,
		first_hit_present, first_hit_time, first_hit_amp, second_hit_present,
		second_hit_time, second_hit_amp, input ready);
	modport sink (input valid, cluster_count, cluster_energy_kev, cluster_time,
		first_hit_present, first_hit_time, first_hit_amp, second_hit_present,
		second_hit_time, second_hit_amp, output ready);
endinterface

interface tewt_out_if;
	logic valid;
	logic ready;
	logic cluster_ok;
	logic first_pass;
	logic second_pass;

	modport source (output valid, cluster_ok, first_pass, second_pass, input ready);
	modport sink (input valid, cluster_ok, first_pass, second_pass, output ready);
endinterface
`default_nettype wire

### design/tewt_expect.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// tewt_expect
// Pipelined expected flight time: divide, square root, scale, divide, multiply, sum.
// -----------------------------------------------------------------------------
module tewt_expect import tewt_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               in_valid,
	input  wire side_t              in_side,
	input  wire cfg_t               coef,
	output logic                    out_valid,
	output side_t                   out_side,
	output logic signed [63:0]      out_tof
);

	localparam int SQ0 = DIV1_STEPS;
	localparam int M0  = SQ0 + SQRT_STEPS;
	localparam int D20 = M0 + 1;
	localparam int P0  = D20 + DIV2_STEPS;

	logic  v  [0:CHAIN_STAGES];
	side_t sd [0:CHAIN_STAGES];

	assign v[0]  = in_valid;
	assign sd[0] = in_side;

	genvar k;
	generate
		for (k = 0; k < CHAIN_STAGES; k++) begin : g_chain
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v[k+1] <= 1'b0;
				end else if (en) begin
					v[k+1] <= v[k];
				end
			end
			always_ff @(posedge clk) begin
				if (en) begin
					sd[k+1] <= sd[k];
				end
			end
		end
	endgenerate

	// inverse energy: 1000 * 2^48 / kev, one quotient bit a stage
	logic [KEV_W-1:0] r1 [0:DIV1_STEPS];
	logic [INV_W-1:0] q1 [0:DIV1_STEPS];
	assign r1[0] = '0;
	assign q1[0] = '0;

	generate
		for (k = 0; k < DIV1_STEPS; k++) begin : g_div1
			logic [KEV_W:0] cur;
			logic           ge;
			assign cur = {r1[k], INV_NUM[INV_W-1-k]};
			assign ge  = cur >= {1'b0, sd[k].kev};
			always_ff @(posedge clk) begin
				if (en) begin
					r1[k+1] <= ge ? KEV_W'(cur - {1'b0, sd[k].kev}) : KEV_W'(cur);
					q1[k+1] <= {q1[k][INV_W-2:0], ge};
				end
			end
		end
	endgenerate

	// integer square root, two radicand bits a stage
	logic [31:0]       r2 [0:SQRT_STEPS];
	logic [ROOT_W-1:0] s2 [0:SQRT_STEPS];
	logic [INV_W-1:0]  x2 [0:SQRT_STEPS];
	assign r2[0] = '0;
	assign s2[0] = '0;
	assign x2[0] = q1[DIV1_STEPS];

	generate
		for (k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
			logic [31:0] cur;
			logic [31:0] trial;
			logic        ge;
			assign cur   = {r2[k][29:0], x2[k][INV_W-1:INV_W-2]};
			assign trial = {1'b0, s2[k], 2'b01};
			assign ge    = cur >= trial;
			always_ff @(posedge clk) begin
				if (en) begin
					r2[k+1] <= ge ? cur - trial : cur;
					s2[k+1] <= {s2[k][ROOT_W-2:0], ge};
					x2[k+1] <= {x2[k][INV_W-3:0], 2'b00};
				end
			end
		end
	endgenerate

	// scale the root by 1000 ahead of the second division
	logic [SCL_W-1:0] d2 [0:DIV2_STEPS];
	logic [ROOT_W-1:0] ss [0:DIV2_STEPS];
	logic [KEV_W-1:0] r3 [0:DIV2_STEPS];
	logic [SCL_W-1:0] q3 [0:DIV2_STEPS];
	assign r3[0] = '0;
	assign q3[0] = '0;

	always_ff @(posedge clk) begin
		if (en) begin
			d2[0] <= SCL_W'(s2[SQRT_STEPS]) * SCL_W'(KEV_PER_MEV);
			ss[0] <= s2[SQRT_STEPS];
		end
	end

	generate
		for (k = 0; k < DIV2_STEPS; k++) begin : g_div2
			logic [KEV_W:0] cur;
			logic           ge;
			assign cur = {r3[k], d2[k][SCL_W-1]};
			assign ge  = cur >= {1'b0, sd[D20+k].kev};
			always_ff @(posedge clk) begin
				if (en) begin
					r3[k+1] <= ge ? KEV_W'(cur - {1'b0, sd[D20+k].kev}) : KEV_W'(cur);
					q3[k+1] <= {q3[k][SCL_W-2:0], ge};
					d2[k+1] <= {d2[k][SCL_W-2:0], 1'b0};
					ss[k+1] <= ss[k];
				end
			end
		end
	endgenerate

	// products of the coefficients
	logic signed [63:0] p1_s1, p2_s1, p3_s1;
	logic [UHI_W-1:0]          u_hi;
	logic [ROOT_FRAC_BITS-1:0] u_lo;
	assign u_hi = q3[DIV2_STEPS][SCL_W-1:ROOT_FRAC_BITS];
	assign u_lo = q3[DIV2_STEPS][ROOT_FRAC_BITS-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s1 <= 64'(coef.c1) * $signed({34'b0, ss[DIV2_STEPS]});
			p2_s1 <= 64'(coef.c2) * $signed({40'b0, u_lo});
			p3_s1 <= 64'(coef.c2) * $signed({49'b0, u_hi});
		end
	end

	logic signed [63:0] frac;
	assign frac = p1_s1 + p2_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			out_tof <= 64'(coef.c0) + p3_s1 + (frac >>> ROOT_FRAC_BITS);
		end
	end

	assign out_valid = v[CHAIN_STAGES];
	assign out_side  = sd[CHAIN_STAGES];

endmodule
`default_nettype wire

### design/tof_energy_window_trigger.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// tof_energy_window_trigger
// Cluster energy check and flight-time window trigger for two forward channels.
// -----------------------------------------------------------------------------
// Throughput: one event per cycle; the whole pipeline holds while the output
//   register is full and not taken.
// Depth is set by the bit-serial stages of the inverse-energy divider, the
//   square root and the second divider.
// Reset (arst_n low) clears all valid bits and loads the register defaults.
module tof_energy_window_trigger import tewt_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	tewt_in_if.sink                evt,
	tewt_out_if.source             res,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	cfg_t     cfg_q;
	reg_idx_t widx;
	logic     wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign widx   = reg_idx_t'(paddr[4:2]);

	// register file: written on the access phase of an APB write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.c0       <= 32'sd460800;
			cfg_q.c1       <= 32'sd81152;
			cfg_q.c2       <= -32'sd920;
			cfg_q.half_win <= 31'd20480;
			cfg_q.emin     <= 14'd200;
			cfg_q.emax     <= 14'd1000;
			cfg_q.thr1     <= 16'd790;
			cfg_q.thr2     <= 16'd780;
		end else if (wr_en) begin
			case (widx)
				REG_C0:   cfg_q.c0       <= pwdata;
				REG_C1:   cfg_q.c1       <= pwdata;
				REG_C2:   cfg_q.c2       <= pwdata;
				REG_HWIN: cfg_q.half_win <= pwdata[30:0];
				REG_EMIN: cfg_q.emin     <= pwdata[KEV_W-1:0];
				REG_EMAX: cfg_q.emax     <= pwdata[KEV_W-1:0];
				REG_THR1: cfg_q.thr1     <= pwdata[AMP_W-1:0];
				REG_THR2: cfg_q.thr2     <= pwdata[AMP_W-1:0];
				default:  ;
			endcase
		end
	end

	always_comb begin
		case (widx)
			REG_C0:   prdata = cfg_q.c0;
			REG_C1:   prdata = cfg_q.c1;
			REG_C2:   prdata = cfg_q.c2;
			REG_HWIN: prdata = {1'b0, cfg_q.half_win};
			REG_EMIN: prdata = {18'b0, cfg_q.emin};
			REG_EMAX: prdata = {18'b0, cfg_q.emax};
			REG_THR1: prdata = {16'b0, cfg_q.thr1};
			REG_THR2: prdata = {16'b0, cfg_q.thr2};
			default:  prdata = '0;
		endcase
	end

	// advance every stage together whenever the output register can move on
	logic res_valid_q;
	logic en;
	assign en        = !res_valid_q || res.ready;
	assign evt.ready = en;

	// entry stage: cluster check, raw flight times, amplitude and presence
	side_t side_d;
	always_comb begin
		side_d.ok   = (evt.cluster_count == 8'd1) && !evt.cluster_time[TIME_W-1] &&
			(evt.cluster_energy_kev != '0) &&
			(evt.cluster_energy_kev >= cfg_q.emin) &&
			(evt.cluster_energy_kev <= cfg_q.emax);
		side_d.kev  = evt.cluster_energy_kev;
		side_d.tof1 = $signed({evt.cluster_time[TIME_W-1], evt.cluster_time}) -
			$signed({evt.first_hit_time[TIME_W-1], evt.first_hit_time});
		side_d.tof2 = $signed({evt.cluster_time[TIME_W-1], evt.cluster_time}) -
			$signed({evt.second_hit_time[TIME_W-1], evt.second_hit_time});
		side_d.pre1 = evt.first_hit_present && (evt.first_hit_amp > cfg_q.thr1);
		side_d.pre2 = evt.second_hit_present && (evt.second_hit_amp > cfg_q.thr2);
	end

	logic  valid_s0;
	side_t side_s0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
		end else if (en) begin
			valid_s0 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s0 <= side_d;
		end
	end

	logic               exp_valid;
	side_t              exp_side;
	logic signed [63:0] exp_tof;

	tewt_expect u_expect (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s0),
		.in_side   (side_s0),
		.coef      (cfg_q),
		.out_valid (exp_valid),
		.out_side  (exp_side),
		.out_tof   (exp_tof)
	);

	// window compare: strictly inside expected time plus or minus half window
	logic signed [63:0] win_lo, win_hi, tof1_x, tof2_x;
	logic               in1, in2;
	assign win_lo = exp_tof - $signed({33'b0, cfg_q.half_win});
	assign win_hi = exp_tof + $signed({33'b0, cfg_q.half_win});
	assign tof1_x = 64'(exp_side.tof1);
	assign tof2_x = 64'(exp_side.tof2);
	assign in1    = (tof1_x > win_lo) && (tof1_x < win_hi);
	assign in2    = (tof2_x > win_lo) && (tof2_x < win_hi);

	logic ok_q, pass1_q, pass2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (en) begin
			res_valid_q <= exp_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_q    <= exp_side.ok;
			pass1_q <= exp_side.ok && exp_side.pre1 && in1;
			pass2_q <= exp_side.ok && exp_side.pre2 && in2;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.cluster_ok  = ok_q;
	assign res.first_pass  = pass1_q;
	assign res.second_pass = pass2_q;

`ifndef NO_ASSERTIONS
	a_pass1_needs_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && pass1_q |-> ok_q) else $error("first pass without cluster");
	a_pass2_needs_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && pass2_q |-> ok_q) else $error("second pass without cluster");
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res.ready |-> !evt.ready) else $error("entry open while stalled");
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid_q |-> evt.ready) else $error("entry closed with empty output");
`endif

endmodule
`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the flight-time and energy window trigger. Events go
// in through a queue-fed driver, and a monitor scores every trigger decision
// against a local prediction of the cluster check and both channel windows.
// -----------------------------------------------------------------------------
module tb_top;
	import tewt_pkg::*;

	typedef struct {
		logic [7:0]         count;
		logic [13:0]        kev;
		logic signed [47:0] ct;
		logic               pres1;
		logic signed [47:0] t1;
		logic [15:0]        amp1;
		logic               pres2;
		logic signed [47:0] t2;
		logic [15:0]        amp2;
	} event_t;

	typedef struct {
		logic ok;
		logic p1;
		logic p2;
	} decision_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	tewt_in_if  evt_ch();
	tewt_out_if res_ch();

	tof_energy_window_trigger dut (
		.clk(clk), .arst_n(arst_n), .evt(evt_ch), .res(res_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// local copy of the register file
	longint c0 = 460800, c1 = 81152, c2 = -920, half_win = 20480;
	int unsigned emin = 200, emax = 1000, thr1 = 790, thr2 = 780;

	event_t    pending_events[$];
	decision_t expected_decisions[$];
	int        snd_idle_pct = 0, rcv_stall_pct = 0;
	int        hold_req = 0, hold_seen = 0, hold_left = 0;
	logic      evt_taken = 1'b0;
	int        err_cnt = 0, n_checked = 0, n_ok = 0, n_pass = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ---------------------------------------------------------------- prediction
	function automatic longint unsigned int_root(longint unsigned x);
		longint unsigned r = 0, b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// expected flight time in ns*1024 for kev >= 1, rounded toward minus infinity
	function automatic longint flight_time(int unsigned kev);
		longint unsigned inv, s, u;
		longint frac;
		inv = (64'd1000 << 48) / kev;
		s = int_root(inv);
		u = (s * 1000) / kev;
		frac = c1 * longint'(s) + c2 * longint'(u & 64'hFF_FFFF);
		return c0 + c2 * longint'(u >> 24) + (frac >>> 24);
	endfunction

	function automatic decision_t trigger_decision(event_t e);
		decision_t d;
		longint t, ct, tof1, tof2;
		ct = e.ct;
		d.ok = (e.count == 8'd1) && (ct >= 0) && (e.kev != 0) && (e.kev >= emin) &&
			(e.kev <= emax);
		d.p1 = 1'b0;
		d.p2 = 1'b0;
		if (d.ok) begin
			t = flight_time(e.kev);
			tof1 = ct - longint'(e.t1);
			tof2 = ct - longint'(e.t2);
			d.p1 = e.pres1 && tof1 > t - half_win && tof1 < t + half_win && e.amp1 > thr1;
			d.p2 = e.pres2 && tof2 > t - half_win && tof2 < t + half_win && e.amp2 > thr2;
		end
		return d;
	endfunction

	// ---------------------------------------------------------------- stimulus
	// Build a single-cluster event whose channel flight times sit at the given
	// offsets from the expected flight time.
	function automatic event_t shaped_event(int unsigned kev, longint off1, longint off2,
			int unsigned a1, int unsigned a2);
		event_t e;
		longint t;
		e.count = 8'd1;
		e.kev = 14'(kev);
		e.ct = {2'b00, $urandom(), 14'($urandom())};
		t = (kev == 0) ? 0 : flight_time(kev);
		e.pres1 = 1'b1;
		e.pres2 = 1'b1;
		e.t1 = 48'(longint'(e.ct) - (t + off1));
		e.t2 = 48'(longint'(e.ct) - (t + off2));
		e.amp1 = 16'(a1);
		e.amp2 = 16'(a2);
		return e;
	endfunction

	function automatic event_t noise_event();
		event_t e;
		e.count = $urandom_range(3) == 0 ? 8'($urandom()) : 8'($urandom_range(2));
		e.kev = 14'($urandom());
		e.ct = {$urandom(), 16'($urandom())};
		e.pres1 = 1'($urandom());
		e.t1 = {$urandom(), 16'($urandom())};
		e.amp1 = 16'($urandom());
		e.pres2 = 1'($urandom());
		e.t2 = {$urandom(), 16'($urandom())};
		e.amp2 = 16'($urandom());
		return e;
	endfunction

	function automatic longint window_offset();
		longint w;
		w = (half_win > 64'd1_000_000) ? 64'd1_000_000 : half_win;
		case ($urandom_range(3))
			0: return w - $urandom_range(1, 0);
			1: return -w + $urandom_range(1, 0);
			default: return longint'($urandom_range(3 * w + 2)) - (3 * w + 2) / 2;
		endcase
	endfunction

	function automatic int unsigned near_amp(int unsigned thr);
		int unsigned a;
		a = thr + $urandom_range(2) - 1;
		return ($urandom_range(3) == 0) ? $urandom_range(65535) : (a > 65535 ? 65535 : a);
	endfunction

	function automatic event_t random_event();
		event_t e;
		int unsigned kev;
		if ($urandom_range(99) < 20) return noise_event();
		if (emin <= emax) kev = $urandom_range(emax, emin);
		else kev = $urandom_range(16383, 1);
		if ($urandom_range(9) == 0) kev = ($urandom_range(1) != 0) ? emin - 1 : emax + 1;
		kev = kev & 14'h3FFF;
		e = shaped_event(kev, window_offset(), window_offset(), near_amp(thr1),
			near_amp(thr2));
		// drop a hit now and then
		if ($urandom_range(7) == 0) e.pres1 = 1'b0;
		if ($urandom_range(7) == 0) e.pres2 = 1'b0;
		return e;
	endfunction

	// ---------------------------------------------------------------- config
	task automatic write_reg(reg_idx_t idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (idx)
			REG_C0:   c0 = longint'($signed(val));
			REG_C1:   c1 = longint'($signed(val));
			REG_C2:   c2 = longint'($signed(val));
			REG_HWIN: half_win = longint'(val[30:0]);
			REG_EMIN: emin = 32'(val[13:0]);
			REG_EMAX: emax = 32'(val[13:0]);
			REG_THR1: thr1 = 32'(val[15:0]);
			REG_THR2: thr2 = 32'(val[15:0]);
			default:  ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic load_config(logic [31:0] v0, v1, v2, v3, v4, v5, v6, v7);
		write_reg(REG_C0, v0);
		write_reg(REG_C1, v1);
		write_reg(REG_C2, v2);
		write_reg(REG_HWIN, v3);
		write_reg(REG_EMIN, v4);
		write_reg(REG_EMAX, v5);
		write_reg(REG_THR1, v6);
		write_reg(REG_THR2, v7);
	endtask

	// hold until every queued event has gone in and every decision has come back
	task automatic drain();
		while (pending_events.size() != 0 || evt_ch.valid || expected_decisions.size() != 0)
			@(posedge clk);
		repeat (140) @(posedge clk);
	endtask

	// ---------------------------------------------------------------- driver
	always @(negedge clk) begin
		if (arst_n && (!evt_ch.valid || evt_taken)) begin
			if (pending_events.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
				event_t e;
				e = pending_events.pop_front();
				evt_ch.valid <= 1'b1;
				evt_ch.cluster_count <= e.count;
				evt_ch.cluster_energy_kev <= e.kev;
				evt_ch.cluster_time <= e.ct;
				evt_ch.first_hit_present <= e.pres1;
				evt_ch.first_hit_time <= e.t1;
				evt_ch.first_hit_amp <= e.amp1;
				evt_ch.second_hit_present <= e.pres2;
				evt_ch.second_hit_time <= e.t2;
				evt_ch.second_hit_amp <= e.amp2;
			end else begin
				evt_ch.valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_req != hold_seen) begin
				hold_seen <= hold_req;
				hold_left <= 400;
				res_ch.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
			end
		end
	end

	// ---------------------------------------------------------------- monitor
	always @(posedge clk) begin
		evt_taken <= evt_ch.valid && evt_ch.ready;
		if (arst_n && evt_ch.valid && evt_ch.ready) begin
			event_t e;
			e.count = evt_ch.cluster_count;
			e.kev = evt_ch.cluster_energy_kev;
			e.ct = evt_ch.cluster_time;
			e.pres1 = evt_ch.first_hit_present;
			e.t1 = evt_ch.first_hit_time;
			e.amp1 = evt_ch.first_hit_amp;
			e.pres2 = evt_ch.second_hit_present;
			e.t2 = evt_ch.second_hit_time;
			e.amp2 = evt_ch.second_hit_amp;
			expected_decisions.push_back(trigger_decision(e));
		end
		if (arst_n && res_ch.valid && res_ch.ready) begin
			decision_t x;
			if (expected_decisions.size() == 0) begin
				$display("%0t: decision with none expected: ok=%b p1=%b p2=%b", $time,
					res_ch.cluster_ok, res_ch.first_pass, res_ch.second_pass);
				err_cnt++;
			end else begin
				x = expected_decisions.pop_front();
				n_checked++;
				n_ok += x.ok;
				n_pass += x.p1 + x.p2;
				if (res_ch.cluster_ok !== x.ok) begin
					$display("%0t: cluster_ok expected %b got %b", $time, x.ok,
						res_ch.cluster_ok);
					err_cnt++;
				end
				if (res_ch.first_pass !== x.p1) begin
					$display("%0t: first_pass expected %b got %b", $time, x.p1,
						res_ch.first_pass);
					err_cnt++;
				end
				if (res_ch.second_pass !== x.p2) begin
					$display("%0t: second_pass expected %b got %b", $time, x.p2,
						res_ch.second_pass);
					err_cnt++;
				end
			end
		end
	end

	// ---------------------------------------------------------------- sequence
	initial begin
		event_t e;
		evt_ch.valid = 1'b0;
		evt_ch.cluster_count = '0;
		evt_ch.cluster_energy_kev = '0;
		evt_ch.cluster_time = '0;
		evt_ch.first_hit_present = 1'b0;
		evt_ch.first_hit_time = '0;
		evt_ch.first_hit_amp = '0;
		evt_ch.second_hit_present = 1'b0;
		evt_ch.second_hit_time = '0;
		evt_ch.second_hit_amp = '0;
		res_ch.ready = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed events on reset defaults
		pending_events.push_back(shaped_event(emin, 0, 0, thr1 + 1, thr2 + 1));
		pending_events.push_back(shaped_event(emax, 0, 0, 65535, 65535));
		pending_events.push_back(shaped_event(emin - 1, 0, 0, 65535, 65535));
		pending_events.push_back(shaped_event(emax + 1, 0, 0, 65535, 65535));
		pending_events.push_back(shaped_event(0, 0, 0, 65535, 65535));      // zero energy
		pending_events.push_back(shaped_event(16383, 0, 0, 65535, 65535));
		// window edges: just inside passes, on the edge fails
		pending_events.push_back(shaped_event(500, half_win - 1, -half_win + 1, 65535, 65535));
		pending_events.push_back(shaped_event(500, half_win, -half_win, 65535, 65535));
		// amplitude equal to threshold fails, zero fails
		pending_events.push_back(shaped_event(600, 0, 0, thr1, thr2));
		pending_events.push_back(shaped_event(600, 0, 0, 0, 0));
		e = shaped_event(700, 0, 0, 65535, 65535);
		e.pres1 = 1'b0;                                                    // absent hits
		pending_events.push_back(e);
		e.pres1 = 1'b1;
		e.pres2 = 1'b0;
		pending_events.push_back(e);
		e = shaped_event(700, 0, 0, 65535, 65535);
		e.count = 8'd0;
		pending_events.push_back(e);
		e.count = 8'd2;
		pending_events.push_back(e);
		e.count = 8'd255;
		pending_events.push_back(e);
		e = shaped_event(700, 0, 0, 65535, 65535);
		e.ct = -48'sd1;                                                    // negative time
		pending_events.push_back(e);
		e.ct = 48'h7FFF_FFFF_FFFF;
		e.t1 = 48'h7FFF_FFFF_FFFF;
		e.t2 = 48'h8000_0000_0000;
		pending_events.push_back(e);
		e.ct = 48'd0;
		e.t1 = 48'd0;
		pending_events.push_back(e);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: ;
				// extreme coefficients, widest window and energy range
				1: load_config(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
					1, 16383, 0, 65535);
				2: load_config(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0,
					16383, 16383, 65535, 0);
				// inverted limits
				3: load_config(460800, 81152, -920, 20480, 900, 300, 790, 780);
				4: load_config($urandom(), $urandom_range(200000), -$urandom_range(5000),
					$urandom_range(50000, 1), 1, 1, $urandom_range(1000), $urandom_range(1000));
				5: load_config(460800, 81152, -920, 20480, 100, 2000, 790, 780);
				default: ;
			endcase
			case (ph % 4)
				0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
				1: begin snd_idle_pct = 84; rcv_stall_pct = 0;  end
				2: begin snd_idle_pct = 0;  rcv_stall_pct = 84; end
				3: begin snd_idle_pct = 18; rcv_stall_pct = 18; end
				default: ;
			endcase
			// fill the pipeline against a long receiver hold-off
			if (ph == 0 || ph == 5) hold_req++;
			for (int i = 0; i < 180; i++)
				pending_events.push_back(random_event());
			drain();
		end

		$display("Checked %0d decisions over 6 register settings and four idling patterns;",
			n_checked);
		$display("%0d events passed the cluster check, %0d channel passes seen.", n_ok, n_pass);
		if (err_cnt == 0) begin
			$display("** tof_energy_window_trigger: PASSED **");
		end else begin
			$display("** tof_energy_window_trigger: FAILED **");
		end
		$finish;
	end

	initial begin
		#8_000_000;
		$display("Timeout with %0d decisions outstanding", expected_decisions.size());
		$display("** tof_energy_window_trigger: FAILED **");
		$finish;
	end

endmodule

### files.f
design/tewt_pkg.sv
design/tewt_ifs.sv
design/tewt_expect.sv
design/tof_energy_window_trigger.sv
tb/sv/tb_top.sv
